// ===== design/sliding_window_range_tracker_top_defines.svh =====
// Assertion macros used by the checker file of the range tracker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SLIDING_WINDOW_RANGE_TRACKER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_RANGE_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SWRT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/swrt_pkg.sv =====
`default_nettype none

package swrt_pkg;

	// Width of the window length register.
	localparam int CFG_BITS = 11;

	// Width of the spread result.
	localparam int SPREAD_BITS = 32;

	// Window length after reset.
	localparam logic [CFG_BITS-1:0] WINDOW_RESET = 11'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic upd_leaf;
		logic upd_climb;
		logic q_setup;
		logic q_load;
		logic q_step;
		logic q_pass2;
		logic q_finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic climb_last;
		logic range_open;
	} status_t;

endpackage

`default_nettype wire

// ===== design/swrt_ctrl.sv =====
`default_nettype none

module swrt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              mode,
	input  logic              out_ready,
	input  swrt_pkg::status_t status,
	output logic              in_ready,
	output logic              out_valid,
	output swrt_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ULEAF,
		S_UCLIMB,
		S_QSETUP,
		S_QLOAD,
		S_QRUN1,
		S_QRUN2,
		S_QFIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Next state and command decode.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = mode ? S_QSETUP : S_ULEAF;
				end
			end
			S_ULEAF: begin
				cmd.upd_leaf = 1'b1;
				state_d      = S_UCLIMB;
			end
			S_UCLIMB: begin
				cmd.upd_climb = 1'b1;
				if (status.climb_last) begin
					state_d = S_IDLE;
				end
			end
			S_QSETUP: begin
				cmd.q_setup = 1'b1;
				state_d     = S_QLOAD;
			end
			S_QLOAD: begin
				cmd.q_load = 1'b1;
				state_d    = S_QRUN1;
			end
			S_QRUN1: begin
				if (status.range_open) begin
					cmd.q_step = 1'b1;
				end else begin
					cmd.q_pass2 = 1'b1;
					state_d     = S_QRUN2;
				end
			end
			S_QRUN2: begin
				if (status.range_open) begin
					cmd.q_step = 1'b1;
				end else begin
					state_d = S_QFIN;
				end
			end
			S_QFIN: begin
				// Wait until the output register is free or being emptied.
				if (!out_valid_q || out_ready) begin
					cmd.q_finish = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.q_finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== design/swrt_dp.sv =====
`default_nettype none

module swrt_dp #(
	parameter int CAPACITY    = 1024,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [swrt_pkg::CFG_BITS-1:0]       window_length,
	output logic                                cfg_ready,
	input  logic [SAMPLE_BITS-1:0]              sample,
	input  swrt_pkg::cmd_t                      cmd,
	output swrt_pkg::status_t                   status,
	output logic [swrt_pkg::SPREAD_BITS-1:0]    spread
);

	localparam int D  = SAMPLE_BITS;
	localparam int NB = $clog2(2 * CAPACITY);
	localparam int LB = $clog2(2 * CAPACITY + 1);
	localparam int PB = $clog2(CAPACITY);
	localparam int CB = $clog2(CAPACITY + 1);
	localparam int KB = (CB > swrt_pkg::CFG_BITS) ? CB : swrt_pkg::CFG_BITS;
	localparam int SB = swrt_pkg::SPREAD_BITS;

	localparam logic [PB-1:0] LAST_POS  = PB'(CAPACITY - 1);
	localparam logic [CB-1:0] FULL      = CB'(CAPACITY);
	localparam logic [NB-1:0] LEAF_BASE = NB'(CAPACITY);
	localparam logic [LB-1:0] CAP_L     = LB'(CAPACITY);
	localparam logic [KB-1:0] CAP_K     = KB'(CAPACITY);
	localparam logic [D-1:0]  ONES      = {D{1'b1}};

	// Tree storage: each entry holds {maximum, minimum} in offset binary.
	logic [2*D-1:0] tree_mem [2*CAPACITY];

	logic [2*D-1:0]               rd_a_q;
	logic [2*D-1:0]               rd_b_q;
	logic                         wr_en;
	logic [NB-1:0]                wr_addr;
	logic [2*D-1:0]               wr_data;
	logic [NB-1:0]                rd_addr_a;
	logic [NB-1:0]                rd_addr_b;

	logic [D-1:0]                 sample_q;
	logic [NB-1:0]                node_q;
	logic [D-1:0]                 cur_max_q;
	logic [D-1:0]                 cur_min_q;
	logic [PB-1:0]                wp_q;
	logic [CB-1:0]                fill_q;
	logic [swrt_pkg::CFG_BITS-1:0] win_q;
	logic [CB-1:0]                k_q;
	logic                         wrap_q;
	logic [LB-1:0]                l_q;
	logic [LB-1:0]                r_q;
	logic                         vld_a_q;
	logic                         vld_b_q;
	logic [D-1:0]                 acc_hi_q;
	logic [D-1:0]                 acc_lo_q;
	logic [SB-1:0]                spread_q;

	logic [NB-1:0]                leaf;
	logic [NB-1:0]                parent;
	logic [D-1:0]                 new_max;
	logic [D-1:0]                 new_min;
	logic [D-1:0]                 a_max;
	logic [D-1:0]                 a_min;
	logic [D-1:0]                 b_max;
	logic [D-1:0]                 b_min;
	logic [D-1:0]                 hi1;
	logic [D-1:0]                 hi2;
	logic [D-1:0]                 lo1;
	logic [D-1:0]                 lo2;
	logic [KB-1:0]                w_ext;
	logic [KB-1:0]                w_sat;
	logic [KB-1:0]                fill_k;
	logic [KB-1:0]                k_d;
	logic [LB-1:0]                wp_l;
	logic [LB-1:0]                k_l;
	logic [LB-1:0]                r_dec;
	logic [D-1:0]                 diff;
	logic [SB+D-1:0]              diff_ext;

	// Update path: leaf address, parent address and the merged node value.
	assign leaf    = LEAF_BASE + NB'(wp_q);
	assign parent  = node_q >> 1;
	assign new_max = (rd_a_q[2*D-1:D] > cur_max_q) ? rd_a_q[2*D-1:D] : cur_max_q;
	assign new_min = (rd_a_q[D-1:0] < cur_min_q) ? rd_a_q[D-1:0] : cur_min_q;

	// Memory port selection.
	always_comb begin
		wr_en   = cmd.upd_leaf | cmd.upd_climb;
		wr_addr = cmd.upd_leaf ? leaf : parent;
		wr_data = cmd.upd_leaf ? {sample_q, sample_q} : {new_max, new_min};
		if (cmd.upd_leaf) begin
			rd_addr_a = leaf ^ NB'(1);
		end else if (cmd.upd_climb) begin
			rd_addr_a = parent ^ NB'(1);
		end else begin
			rd_addr_a = l_q[NB-1:0];
		end
	end

	assign r_dec     = r_q - LB'(1);
	assign rd_addr_b = r_dec[NB-1:0];

	// Tree memory with registered read data on two ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tree_mem[wr_addr] <= wr_data;
		end
		rd_a_q <= tree_mem[rd_addr_a];
		rd_b_q <= tree_mem[rd_addr_b];
	end

	// Sample capture and the walk up the tree.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= {~sample[D-1], sample[D-2:0]};
		end
		if (cmd.upd_leaf) begin
			node_q    <= leaf;
			cur_max_q <= sample_q;
			cur_min_q <= sample_q;
		end else if (cmd.upd_climb) begin
			node_q    <= parent;
			cur_max_q <= new_max;
			cur_min_q <= new_min;
		end
	end

	// Write position, fill count and window length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			win_q  <= swrt_pkg::WINDOW_RESET;
		end else begin
			if (cfg_valid) begin
				win_q <= window_length;
			end
			if (cmd.upd_leaf) begin
				wp_q <= (wp_q == LAST_POS) ? '0 : wp_q + PB'(1);
				if (fill_q != FULL) begin
					fill_q <= fill_q + CB'(1);
				end
			end
		end
	end

	// Query setup: clamp the window and limit it to the samples held.
	assign w_ext  = KB'(win_q);
	assign fill_k = KB'(fill_q);
	always_comb begin
		if (win_q == '0) begin
			w_sat = KB'(1);
		end else if (w_ext > CAP_K) begin
			w_sat = CAP_K;
		end else begin
			w_sat = w_ext;
		end
		k_d = (w_sat < fill_k) ? w_sat : fill_k;
	end

	assign wp_l = LB'(wp_q);
	assign k_l  = LB'(k_q);

	// Range bounds: the first pass, then the wrapped tail if any.
	always_ff @(posedge clk) begin
		if (cmd.q_setup) begin
			k_q <= CB'(k_d);
		end
		if (cmd.q_load) begin
			if (wp_l >= k_l) begin
				l_q    <= wp_l - k_l + CAP_L;
				r_q    <= wp_l + CAP_L;
				wrap_q <= 1'b0;
			end else begin
				l_q    <= wp_l + CAP_L + CAP_L - k_l;
				r_q    <= CAP_L + CAP_L;
				wrap_q <= 1'b1;
			end
		end else if (cmd.q_pass2) begin
			l_q <= CAP_L;
			r_q <= wrap_q ? CAP_L + wp_l : CAP_L;
		end else if (cmd.q_step) begin
			l_q <= (l_q + LB'(l_q[0])) >> 1;
			r_q <= r_q >> 1;
		end
	end

	// Flags that mark which read ports carry a node of the range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			vld_a_q <= cmd.q_step & l_q[0];
			vld_b_q <= cmd.q_step & r_q[0];
		end
	end

	// Fold the read nodes into the running maximum and minimum.
	assign a_max = rd_a_q[2*D-1:D];
	assign a_min = rd_a_q[D-1:0];
	assign b_max = rd_b_q[2*D-1:D];
	assign b_min = rd_b_q[D-1:0];
	assign hi1   = (vld_a_q && (a_max > acc_hi_q)) ? a_max : acc_hi_q;
	assign hi2   = (vld_b_q && (b_max > hi1)) ? b_max : hi1;
	assign lo1   = (vld_a_q && (a_min < acc_lo_q)) ? a_min : acc_lo_q;
	assign lo2   = (vld_b_q && (b_min < lo1)) ? b_min : lo1;

	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			acc_hi_q <= '0;
			acc_lo_q <= (k_q == '0) ? '0 : ONES;
		end else begin
			acc_hi_q <= hi2;
			acc_lo_q <= lo2;
		end
	end

	// Result register: difference taken at sample width, then fit to 32 bits.
	assign diff     = acc_hi_q - acc_lo_q;
	assign diff_ext = {{SB{1'b0}}, diff};

	always_ff @(posedge clk) begin
		if (cmd.q_finish) begin
			spread_q <= diff_ext[SB-1:0];
		end
	end

	assign status.climb_last = (parent == NB'(1));
	assign status.range_open = (l_q < r_q);
	assign spread            = spread_q;
	assign cfg_ready         = 1'b1;

endmodule

`default_nettype wire

// ===== design/sliding_window_range_tracker_top.sv =====
// Sliding-window range tracker.
// Input channel (in_valid/in_ready): mode 0 appends a signed sample, mode 1
// requests the spread (maximum minus minimum) of the last window_length
// samples, or of all samples held when fewer have arrived; 0 before any.
// Output channel (out_valid/out_ready): one spread per query, none per append.
// Configuration channel (cfg_valid/cfg_ready): writes window_length; it is
// always ready and is meant to be written while the block is idle.
// One request is in work at a time. An append is an accept step, a leaf write,
// then one tree level refreshed per cycle through the tree memory's write port.
// A query is accept, setup and load steps, two range passes of one level per
// cycle on the two read ports, each closed by a closing step, and a result step.
// The result sits in an output register, so a new request is taken while it
// waits; a finished query holds until that register is free.
// Reset clears the write position, fill count and control state and sets the
// window length to 1. Tree contents are not cleared; only written nodes are
// ever folded into a result.
`default_nettype none

module sliding_window_range_tracker_top #(
	parameter int CAPACITY    = 1024,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [swrt_pkg::CFG_BITS-1:0]    window_length,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic [SAMPLE_BITS-1:0]           sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [swrt_pkg::SPREAD_BITS-1:0] spread
);

	swrt_pkg::cmd_t    cmd;
	swrt_pkg::status_t status;

	// Sequencer for appends and queries.
	swrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.out_ready (out_ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// Tree memory, range walker and result register.
	swrt_dp #(
		.CAPACITY    (CAPACITY),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.window_length (window_length),
		.cfg_ready     (cfg_ready),
		.sample        (sample),
		.cmd           (cmd),
		.status        (status),
		.spread        (spread)
	);

endmodule

`default_nettype wire

// ===== design/swrt_checker.sv =====
`default_nettype none
`include "sliding_window_range_tracker_top_defines.svh"

module swrt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_ready,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [swrt_pkg::SPREAD_BITS-1:0] spread
);

	// A stalled result keeps its valid and its value.
	`SWRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out_valid dropped while stalled")
	`SWRT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(spread), "spread changed while stalled")

	// The block is still busy in the cycle after it takes a request.
	`SWRT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken back to back")

	// No result can appear in the cycle after a request is taken.
	`SWRT_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready && !out_valid, !out_valid, "result too early")

	// The configuration port never stalls.
	`SWRT_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "cfg_ready low")

endmodule

bind sliding_window_range_tracker_top swrt_checker u_swrt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.spread    (spread)
);

`default_nettype wire

// ===== test/tb_sliding_window_range_tracker_top.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_range_tracker_top;

	localparam int CAPACITY    = 1024;
	localparam int SAMPLE_BITS = 32;
	// Cycles to let pass after the last spread so that a trailing append retires.
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CHUNK_ITEMS  = 150;

	typedef enum logic {
		MODE_APPEND = 1'b0,
		MODE_QUERY  = 1'b1
	} mode_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [swrt_pkg::CFG_BITS-1:0]    window_length;
	logic                             in_valid;
	logic                             in_ready;
	logic                             mode;
	logic [SAMPLE_BITS-1:0]           sample;
	logic                             out_valid;
	logic                             out_ready;
	logic [swrt_pkg::SPREAD_BITS-1:0] spread;

	// Predictor state: the recent samples, in arrival order around a ring.
	logic signed [SAMPLE_BITS-1:0]    sample_history [CAPACITY];
	int                               history_head;
	int                               history_fill;
	logic [swrt_pkg::CFG_BITS-1:0]    window_setting;
	logic [swrt_pkg::SPREAD_BITS-1:0] pending_spreads [$];
	logic [swrt_pkg::SPREAD_BITS-1:0] expected_spread;

	int send_idle_pct;
	int recv_stall_pct;
	int error_count;
	int cycle_count;
	int appends_sent;
	int queries_sent;
	int spreads_checked;
	int settings_used;

	sliding_window_range_tracker_top #(
		.CAPACITY   (CAPACITY),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.window_length(window_length),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.spread       (spread)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// The run ends here if the block stops making progress.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d spreads still pending",
				cycle_count, pending_spreads.size());
			$display("tb_sliding_window_range_tracker_top: done, errors");
			$finish;
		end
	end

	task automatic report_mismatch(input string what,
		input logic [swrt_pkg::SPREAD_BITS-1:0] want,
		input logic [swrt_pkg::SPREAD_BITS-1:0] got);
		$display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
		error_count++;
	endtask

	// Spread of the most recent samples under the current window setting.
	function automatic logic [swrt_pkg::SPREAD_BITS-1:0] predict_spread();
		int    span;
		int    slot;
		longint hi_val;
		longint lo_val;
		span = int'(window_setting);
		if (span == 0)
			span = 1;
		if (span > CAPACITY)
			span = CAPACITY;
		if (span > history_fill)
			span = history_fill;
		if (span == 0)
			return '0;
		slot = (history_head + CAPACITY - 1) % CAPACITY;
		hi_val = sample_history[slot];
		lo_val = sample_history[slot];
		for (int i = 1; i < span; i++) begin
			slot = (history_head + CAPACITY - 1 - i) % CAPACITY;
			if (sample_history[slot] > hi_val)
				hi_val = sample_history[slot];
			if (sample_history[slot] < lo_val)
				lo_val = sample_history[slot];
		end
		return swrt_pkg::SPREAD_BITS'(hi_val - lo_val);
	endfunction

	// Result side: random stalls and comparison against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_spreads.size() == 0) begin
				report_mismatch("spread with no query waiting", '0, spread);
			end else begin
				expected_spread = pending_spreads.pop_front();
				if (spread !== expected_spread)
					report_mismatch("spread", expected_spread, spread);
				spreads_checked++;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Sends one request, holding it until accepted, then updates the predictor.
	task automatic send_request(input mode_t m, input logic [SAMPLE_BITS-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		sample <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (m == MODE_QUERY) begin
			pending_spreads.push_back(predict_spread());
			queries_sent++;
		end else begin
			sample_history[history_head] = s;
			history_head = (history_head + 1) % CAPACITY;
			if (history_fill < CAPACITY)
				history_fill++;
			appends_sent++;
		end
	endtask

	// Holds off new requests until every spread is back and the block has settled.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_spreads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input logic [swrt_pkg::CFG_BITS-1:0] len);
		wait_idle();
		cfg_valid <= 1'b1;
		window_length <= len;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		window_setting = len;
		settings_used++;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(5))
			0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			2: return SAMPLE_BITS'(int'($urandom_range(15)) - 8);
			default: return $urandom;
		endcase
	endfunction

	// Queries with nothing appended must give zero, whatever the window.
	task automatic test_empty_query();
		send_request(MODE_QUERY, $urandom);
		set_window(swrt_pkg::CFG_BITS'(2047));
		send_request(MODE_QUERY, '1);
	endtask

	// Largest and smallest samples, alone and together.
	task automatic test_extremes();
		send_request(MODE_APPEND, 32'h7fff_ffff);
		send_request(MODE_QUERY, '0);
		send_request(MODE_APPEND, 32'h8000_0000);
		send_request(MODE_QUERY, '0);
		send_request(MODE_APPEND, '0);
		send_request(MODE_APPEND, '1);
		send_request(MODE_QUERY, 32'h1234_5678);
	endtask

	// Window of zero acts as one; windows past the capacity saturate.
	task automatic test_window_edges();
		set_window('0);
		send_request(MODE_QUERY, '0);
		set_window(swrt_pkg::CFG_BITS'(2));
		send_request(MODE_QUERY, '0);
		set_window(swrt_pkg::CFG_BITS'(CAPACITY));
		send_request(MODE_QUERY, '0);
		set_window(swrt_pkg::CFG_BITS'(CAPACITY + 1));
		send_request(MODE_QUERY, '0);
		set_window(swrt_pkg::CFG_BITS'(3));
		send_request(MODE_APPEND, 32'd5);
		send_request(MODE_QUERY, '0);
	endtask

	// Mixed appends and queries under four handshake profiles. The window is
	// rewritten between chunks, which also makes the sender wait for every
	// outstanding spread before going on.
	task automatic test_random_traffic();
		int idle_profile [4];
		int stall_profile [4];
		int chunk_windows [12];
		int chunk;
		idle_profile = '{0, 80, 0, 21};
		stall_profile = '{0, 0, 80, 21};
		chunk_windows = '{1025, 3, 1024, 0, 2047, 17, 1, 600, 1023, 2,
			$urandom_range(1023, 4), $urandom_range(2047, 1026)};
		chunk = 0;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_profile[p];
			recv_stall_pct = stall_profile[p];
			for (int c = 0; c < RANDOM_ITEMS / (4 * CHUNK_ITEMS); c++) begin
				set_window(swrt_pkg::CFG_BITS'(chunk_windows[chunk % 12]));
				chunk++;
				for (int i = 0; i < CHUNK_ITEMS; i++) begin
					if ($urandom_range(99) < 35)
						send_request(MODE_QUERY, $urandom);
					else
						send_request(MODE_APPEND, random_sample());
				end
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		window_length <= swrt_pkg::WINDOW_RESET;
		in_valid <= 1'b0;
		mode <= MODE_APPEND;
		sample <= '0;
		out_ready <= 1'b0;
		history_head = 0;
		history_fill = 0;
		window_setting = swrt_pkg::WINDOW_RESET;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		error_count = 0;
		cycle_count = 0;
		appends_sent = 0;
		queries_sent = 0;
		spreads_checked = 0;
		settings_used = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_query();
		test_extremes();
		test_window_edges();
		test_random_traffic();
		wait_idle();

		$display("covered %0d appends and %0d spread queries (%0d checked)",
			appends_sent, queries_sent, spreads_checked);
		$display("over %0d window settings in %0d cycles", settings_used, cycle_count);
		if (error_count == 0 && pending_spreads.size() == 0)
			$display("tb_sliding_window_range_tracker_top: done, clean");
		else
			$display("tb_sliding_window_range_tracker_top: done, errors");
		$finish;
	end

endmodule
